FILE: sv/cms_pkg.sv
// ----------------------------------------------------------------------------
// cms_pkg: shared types and constants of the count-min sketch
// sizes, command codes, hash helpers and the front/back queue entry
// ----------------------------------------------------------------------------
package cms_pkg;

  localparam int MAX_ROWS    = 4;
  localparam int MAX_COLUMNS = 1024;
  localparam int MAX_HASHES  = 4;

  localparam int ROW_W  = $clog2(MAX_ROWS);
  localparam int COL_W  = $clog2(MAX_COLUMNS);
  localparam int HSH_W  = (MAX_HASHES > 1) ? $clog2(MAX_HASHES) : 1;
  localparam int ADDR_W = ROW_W + COL_W;
  localparam int DEPTH  = MAX_ROWS * MAX_COLUMNS;

  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 11;

  typedef enum logic [1:0] {
    CMD_QUERY  = 2'd0,
    CMD_INCR   = 2'd1,
    CMD_CLEAR  = 2'd2,
    CMD_INSERT = 2'd3
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ROWS   = 2'd0,
    CFG_COLS   = 2'd1,
    CFG_HASHES = 2'd2,
    CFG_NONE   = 2'd3
  } cfg_idx_t;

  // back-end sequencer
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_HASH,
    ST_MOD,
    ST_READ,
    ST_UPD,
    ST_CLR,
    ST_DONE
  } state_t;

  // queued request: classified by the front part
  typedef struct packed {
    cmd_t        cmd;
    logic [31:0] key;
  } req_t;

  // one byte round of the one-at-a-time hash
  function automatic logic [31:0] oaat_round(logic [31:0] h, logic [7:0] b);
    logic [31:0] t;
    t = h + {24'd0, b};
    t = t + (t << 10);
    t = t ^ (t >> 6);
    return t;
  endfunction

  function automatic logic [31:0] oaat_final(logic [31:0] h);
    logic [31:0] t;
    t = h + (h << 3);
    t = t ^ (t >> 11);
    t = t + (t << 15);
    return t;
  endfunction

endpackage

FILE: sv/cms_if.sv
// ----------------------------------------------------------------------------
// cms_in_if / cms_out_if: request and result channels
// valid/ready handshake with the payload fields
// ----------------------------------------------------------------------------
interface cms_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [31:0] key;
  modport source (output valid, cmd, key, input ready);
  modport sink (input valid, cmd, key, output ready);
endinterface

interface cms_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] estimate;
  logic        status;
  modport source (output valid, estimate, status, input ready);
  modport sink (input valid, estimate, status, output ready);
endinterface

FILE: sv/count_min_sketch_top.sv
// ----------------------------------------------------------------------------
// count_min_sketch_top: count-min sketch over 32-bit keys
// query/increment walk every row and hash position: byte-wise
//   hash, 32-step bit-serial modulo, memory read, update per position
// clear: one counter memory word per cycle; insert or no rows/hashes: no walk
// one request in flight in the engine; a two-entry queue takes the next;
//   after reset a clearing pass over all counter words runs and no request
//   is taken until it is done
// ----------------------------------------------------------------------------
module count_min_sketch_top (
  input  logic        clk,
  input  logic        rst_n,
  cms_in_if.sink      in_ch,
  cms_out_if.source   out_ch,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_idx,
  input  logic [10:0] cfg_data
);
  import cms_pkg::*;

  // configuration registers
  logic [2:0]  row_count_r;
  logic [10:0] column_count_r;
  logic [2:0]  hashes_per_row_r;

  logic  q_valid, q_pop, init_busy;
  req_t  q_req;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_count_r      <= 3'd4;
      column_count_r   <= 11'd1024;
      hashes_per_row_r <= 3'd1;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_idx))
        CFG_ROWS:   row_count_r      <= cfg_data[2:0];
        CFG_COLS:   column_count_r   <= cfg_data;
        CFG_HASHES: hashes_per_row_r <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  // front part: accepts and queues requests
  cms_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .q_valid (q_valid),
    .q_pop   (q_pop),
    .q_req   (q_req)
  );

  // back part: hashing, counter memory and result register
  cms_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_pop      (q_pop),
    .q_req      (q_req),
    .rows_cfg   (row_count_r),
    .cols_cfg   (column_count_r),
    .hashes_cfg (hashes_per_row_r),
    .init_busy  (init_busy),
    .out_ch     (out_ch)
  );

  top_boot_no_pop: assert property (@(posedge clk) disable iff (!rst_n)
    init_busy |-> !q_pop) else $error("request during clearing pass");

endmodule

FILE: sv/cms_front.sv
// ----------------------------------------------------------------------------
// cms_front: request intake
// classifies commands and keeps a two-entry queue toward the back end
// ----------------------------------------------------------------------------
module cms_front (
  input  logic          clk,
  input  logic          rst_n,
  cms_in_if.sink        in_ch,
  output logic          q_valid,
  input  logic          q_pop,
  output cms_pkg::req_t q_req
);
  import cms_pkg::*;

  req_t       buf_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       push;

  assign in_ch.ready = (cnt_r != 2'd2);
  assign push        = in_ch.valid && in_ch.ready;
  assign q_valid     = (cnt_r != 2'd0);
  assign q_req       = buf_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      buf_r[wp_r] <= '{cmd: cmd_t'(in_ch.cmd), key: in_ch.key};
    end
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (q_pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, q_pop};
    end
  end

  cms_front_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r == 2'd2 |-> !push || q_pop) else $error("queue overflow");
  cms_front_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> cnt_r != 2'd0) else $error("queue underflow");
  cms_front_count: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= 2'd2) else $error("queue count out of range");

endmodule

FILE: sv/cms_back.sv
// ----------------------------------------------------------------------------
// cms_back: sketch engine
// walks rows and hashes over one counter memory, clears, and emits results
// ----------------------------------------------------------------------------
module cms_back (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      q_valid,
  output logic                      q_pop,
  input  cms_pkg::req_t             q_req,
  input  logic [2:0]                rows_cfg,
  input  logic [10:0]               cols_cfg,
  input  logic [2:0]                hashes_cfg,
  output logic                      init_busy,
  cms_out_if.source                 out_ch
);
  import cms_pkg::*;

  logic [31:0] mem [DEPTH];
  logic [31:0] rdata_r;

  state_t       state_r, state_nxt;
  req_t         req_r;
  logic [ROW_W:0] rows_r;
  logic [HSH_W:0] hsh_r;
  logic [10:0]  cols_r;
  logic [ROW_W-1:0] row_r;
  logic [HSH_W-1:0] hix_r;
  logic [2:0]   byte_r;
  logic [31:0]  h_r;
  logic [31:0]  rem_r;
  logic [5:0]   mstep_r;
  logic [ADDR_W-1:0] addr_r;
  logic [ADDR_W:0]   clr_r;
  logic [31:0]  est_r;
  logic         ovalid_r;
  logic [31:0]  oest_r;
  logic         ostat_r;
  logic         boot_r;

  logic [31:0] word;
  logic        last_pos;
  logic [32:0] shifted;
  logic        out_free;
  logic        clr_last;

  assign out_free  = !ovalid_r || out_ch.ready;
  assign init_busy = boot_r;
  assign clr_last  = (clr_r == (ADDR_W+1)'(DEPTH - 1));
  assign word = ({{(32-ROW_W){1'b0}}, row_r} + req_r.key) * 32'd7
              + {{(32-ROW_W){1'b0}}, row_r} * 32'd13
              + {{(32-HSH_W){1'b0}}, hix_r} * 32'd31;
  assign last_pos = ({1'b0, row_r} == rows_r - 1'b1) && ({1'b0, hix_r} == hsh_r - 1'b1);
  // restoring remainder: shift one bit of the hash in, subtract modulus
  assign shifted = {rem_r, h_r[31]};

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (boot_r) state_nxt = ST_CLR;
        else if (q_valid) begin
          unique case (q_req.cmd)
            CMD_CLEAR: state_nxt = ST_CLR;
            CMD_INSERT: state_nxt = ST_DONE;
            default: state_nxt = (rows_cfg == 3'd0 || hashes_cfg == 3'd0) ? ST_DONE : ST_HASH;
          endcase
        end
      end
      ST_HASH: if (byte_r == 3'd4) state_nxt = ST_MOD;
      ST_MOD:  if (mstep_r == 6'd32) state_nxt = ST_READ;
      ST_READ: state_nxt = ST_UPD;
      ST_UPD:  state_nxt = last_pos ? ST_DONE : ST_HASH;
      ST_CLR:  if (clr_last) state_nxt = boot_r ? ST_IDLE : ST_DONE;
      ST_DONE: if (out_free) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    q_pop = (state_r == ST_IDLE) && !boot_r && q_valid;
  end

  assign out_ch.valid    = ovalid_r;
  assign out_ch.estimate = oest_r;
  assign out_ch.status   = ostat_r;

  // memory port: one write (clear or increment) and one registered read per cycle
  always_ff @(posedge clk) begin
    if (state_r == ST_CLR) mem[clr_r[ADDR_W-1:0]] <= 32'd0;
    else if (state_r == ST_UPD && req_r.cmd == CMD_INCR) mem[addr_r] <= rdata_r + 32'd1;
    rdata_r <= mem[addr_r];
  end

  // clear address walk
  always_ff @(posedge clk) begin
    if (!rst_n) clr_r <= '0;
    else if (q_pop) clr_r <= '0;
    else if (state_r == ST_CLR) clr_r <= clr_r + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      req_r  <= q_req;
      rows_r <= (rows_cfg > 3'(MAX_ROWS)) ? (ROW_W+1)'(MAX_ROWS) : (ROW_W+1)'(rows_cfg);
      hsh_r  <= (hashes_cfg > 3'(MAX_HASHES)) ? (HSH_W+1)'(MAX_HASHES)
              : (HSH_W+1)'(hashes_cfg);
      cols_r <= (cols_cfg == 11'd0) ? 11'd1
              : (cols_cfg > 11'(MAX_COLUMNS)) ? 11'(MAX_COLUMNS) : cols_cfg;
      row_r  <= '0;
      hix_r  <= '0;
      byte_r <= 3'd0;
      h_r    <= 32'd0;
      est_r  <= 32'hFFFF_FFFF;
    end
    unique case (state_r)
      ST_HASH: begin
        if (byte_r == 3'd4) begin
          h_r     <= oaat_final(h_r);
          rem_r   <= 32'd0;
          mstep_r <= 6'd0;
        end else begin
          h_r    <= oaat_round(h_r, word[8*byte_r[1:0] +: 8]);
          byte_r <= byte_r + 3'd1;
        end
      end
      ST_MOD: begin
        if (mstep_r != 6'd32) begin
          h_r <= {h_r[30:0], 1'b0};
          if (shifted >= {22'd0, cols_r}) rem_r <= 32'(shifted - {22'd0, cols_r});
          else rem_r <= shifted[31:0];
          mstep_r <= mstep_r + 6'd1;
        end else begin
          addr_r <= {row_r, rem_r[COL_W-1:0]};
        end
      end
      ST_UPD: begin
        if (rdata_r < est_r) est_r <= rdata_r;
        byte_r <= 3'd0;
        h_r    <= 32'd0;
        if ({1'b0, hix_r} == hsh_r - 1'b1) begin
          hix_r <= '0;
          row_r <= row_r + 1'b1;
        end else begin
          hix_r <= hix_r + 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      ovalid_r <= 1'b0;
      boot_r   <= 1'b1;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_CLR && clr_last) boot_r <= 1'b0;
      if (state_r == ST_DONE && out_free) begin
        ovalid_r <= 1'b1;
        oest_r   <= (req_r.cmd == CMD_QUERY) ? ((rows_r == '0 || hsh_r == '0) ?
                    32'hFFFF_FFFF : est_r) : 32'd0;
        ostat_r  <= (req_r.cmd == CMD_INSERT);
      end else if (out_ch.ready) begin
        ovalid_r <= 1'b0;
      end
    end
  end

  cms_back_boot_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    boot_r |-> !q_pop) else $error("request taken during clearing pass");
  cms_back_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> state_r != ST_IDLE) else $error("popped request not started");
  cms_back_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    ovalid_r && !out_ch.ready |=> ovalid_r && $stable(oest_r))
    else $error("result dropped");

endmodule

FILE: dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: count-min sketch block testbench
// drives query, increment, clear and insert requests through the request
// channel, predicts each estimate and status from a local sketch copy and
// compares every result in order; configuration changes only between phases
// ----------------------------------------------------------------------------
module tb_top;
  import cms_pkg::*;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [1:0]  cfg_idx;
  logic [10:0] cfg_data;

  cms_in_if  in_ch ();
  cms_out_if out_ch ();

  count_min_sketch_top i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch.sink),
    .out_ch   (out_ch.source),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data)
  );

  // expected result of one request
  typedef struct {
    logic [31:0] estimate;
    logic        status;
  } sketch_result_t;

  // directed stimulus row; check_fixed marks rows with a typed-in answer
  typedef struct {
    cmd_t        cmd;
    logic [31:0] key;
    bit          check_fixed;
    logic [31:0] estimate;
    logic        status;
  } stim_row_t;

  // local copy of the sketch and its settings
  logic [31:0] sketch_mem [DEPTH];
  logic [2:0]  rows_reg;
  logic [10:0] cols_reg;
  logic [2:0]  hashes_reg;

  sketch_result_t expected_q[$];
  int          fail_count;
  int          idle_cycles;
  int          send_idle_pct;
  int          recv_idle_pct;
  bit          hold_off;
  bit          done_flag;

  localparam int WATCHDOG_LIMIT = 60000;

  initial clk = 1'b0;
  always #2 clk = ~clk;

  // jenkins one-at-a-time over the four little-endian bytes of a word
  function automatic logic [31:0] jenkins_word(logic [31:0] w);
    logic [31:0] h;
    h = '0;
    for (int b = 0; b < 4; b++) begin
      h = h + {24'd0, w[8*b +: 8]};
      h = h + (h << 10);
      h = h ^ (h >> 6);
    end
    h = h + (h << 3);
    h = h ^ (h >> 11);
    h = h + (h << 15);
    return h;
  endfunction

  // apply one request to the local sketch and return its expected result
  function automatic sketch_result_t sketch_apply(cmd_t cmd, logic [31:0] key);
    sketch_result_t res;
    int unsigned    rows, hashes, cols, col;
    logic [31:0]    w;
    rows   = (rows_reg > MAX_ROWS) ? MAX_ROWS : rows_reg;
    hashes = (hashes_reg > MAX_HASHES) ? MAX_HASHES : hashes_reg;
    cols   = (cols_reg == 0) ? 1 : ((cols_reg > MAX_COLUMNS) ? MAX_COLUMNS : cols_reg);
    res.estimate = '0;
    res.status   = 1'b0;
    case (cmd)
      CMD_QUERY: begin
        res.estimate = 32'hFFFF_FFFF;
        for (int unsigned r = 0; r < rows; r++)
          for (int unsigned h = 0; h < hashes; h++) begin
            w   = (key + r) * 32'd7 + r * 32'd13 + 32'd31 * h;
            col = jenkins_word(w) % cols;
            if (sketch_mem[r*MAX_COLUMNS + col] < res.estimate)
              res.estimate = sketch_mem[r*MAX_COLUMNS + col];
          end
      end
      CMD_INCR: begin
        for (int unsigned r = 0; r < rows; r++)
          for (int unsigned h = 0; h < hashes; h++) begin
            w   = (key + r) * 32'd7 + r * 32'd13 + 32'd31 * h;
            col = jenkins_word(w) % cols;
            sketch_mem[r*MAX_COLUMNS + col] = sketch_mem[r*MAX_COLUMNS + col] + 1;
          end
      end
      CMD_CLEAR: begin
        foreach (sketch_mem[i]) sketch_mem[i] = '0;
      end
      default: res.status = 1'b1;
    endcase
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
    fail_count++;
  endtask

  // send one request and queue its prediction; the predictor runs at acceptance
  // valid stays high afterwards until the next idle cycle or the end of a phase
  task automatic send_request(cmd_t cmd, logic [31:0] key);
    while (send_idle_pct > 0 && $urandom_range(99, 0) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.cmd   <= cmd;
    in_ch.key   <= key;
    do @(posedge clk); while (!in_ch.ready);
    expected_q.push_back(sketch_apply(cmd, key));
  endtask

  // directed check: typed-in answer must agree with the predictor too
  task automatic send_row(stim_row_t row);
    sketch_result_t pred;
    send_request(row.cmd, row.key);
    pred = expected_q[$];
    if (row.check_fixed && (pred.estimate !== row.estimate || pred.status !== row.status))
      report_mismatch("directed table", pred.estimate, row.estimate);
  endtask

  // write a register while the block is idle
  task automatic write_cfg(cfg_idx_t idx, logic [10:0] value);
    while (expected_q.size() != 0) @(posedge clk);
    // a result may still be on its way out, plus a full clear pass
    repeat (4200) @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_ROWS:   rows_reg   = value[2:0];
      CFG_COLS:   cols_reg   = value;
      CFG_HASHES: hashes_reg = value[2:0];
      default: ;
    endcase
  endtask

  // random key mostly from a small pool so counts build up
  function automatic logic [31:0] pick_key();
    if ($urandom_range(3, 0) != 0) return $urandom_range(15, 0) * 32'h0101_0101;
    return $urandom();
  endfunction

  task automatic random_phase(int n);
    int   sel;
    cmd_t cmd;
    for (int i = 0; i < n; i++) begin
      sel = $urandom_range(99, 0);
      if (sel < 45)      cmd = CMD_INCR;
      else if (sel < 90) cmd = CMD_QUERY;
      else if (sel < 93) cmd = CMD_CLEAR;
      else               cmd = CMD_INSERT;
      send_request(cmd, pick_key());
    end
    in_ch.valid <= 1'b0;
  endtask

  // receiver: random stall plus an optional long hold-off
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (hold_off) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= !(recv_idle_pct > 0 && $urandom_range(99, 0) < recv_idle_pct);
    end
  end

  // result checker
  always @(posedge clk) begin
    sketch_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_q.size() == 0) begin
        report_mismatch("unexpected result", out_ch.estimate, '0);
      end else begin
        want = expected_q.pop_front();
        if (out_ch.estimate !== want.estimate)
          report_mismatch("estimate", out_ch.estimate, want.estimate);
        if (out_ch.status !== want.status)
          report_mismatch("status", out_ch.status, want.status);
      end
    end
  end

  // watchdog: cycles without any accepted request or result
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
        || cfg_we || done_flag) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  initial begin
    stim_row_t table_rows[$];
    // directed rows: extremes, every command and the special cases
    table_rows = '{
      '{CMD_QUERY,  32'h0000_0000, 1'b1, 32'd0, 1'b0},  // fresh sketch reads zero
      '{CMD_QUERY,  32'hFFFF_FFFF, 1'b1, 32'd0, 1'b0},
      '{CMD_INSERT, 32'h1234_5678, 1'b1, 32'd0, 1'b1},  // insert-only rejected
      '{CMD_INCR,   32'h0000_0000, 1'b1, 32'd0, 1'b0},
      '{CMD_INCR,   32'h0000_0000, 1'b1, 32'd0, 1'b0},
      '{CMD_INCR,   32'hFFFF_FFFF, 1'b1, 32'd0, 1'b0},
      '{CMD_QUERY,  32'h0000_0000, 1'b0, 32'd0, 1'b0},
      '{CMD_QUERY,  32'hFFFF_FFFF, 1'b0, 32'd0, 1'b0},
      '{CMD_INSERT, 32'hFFFF_FFFF, 1'b1, 32'd0, 1'b1},
      '{CMD_CLEAR,  32'hA5A5_A5A5, 1'b1, 32'd0, 1'b0},
      '{CMD_QUERY,  32'h0000_0000, 1'b1, 32'd0, 1'b0},  // cleared
      '{CMD_INCR,   32'h5A5A_5A5A, 1'b1, 32'd0, 1'b0},
      '{CMD_QUERY,  32'h5A5A_5A5A, 1'b0, 32'd0, 1'b0}
    };

    rst_n = 1'b0;
    cfg_we = 1'b0; cfg_idx = CFG_NONE; cfg_data = '0;
    in_ch.valid = 1'b0; in_ch.cmd = CMD_QUERY; in_ch.key = '0;
    hold_off = 1'b0; done_flag = 1'b0; fail_count = 0;
    send_idle_pct = 31; recv_idle_pct = 86;
    rows_reg = 3'd4; cols_reg = 11'd1024; hashes_reg = 3'd1;
    foreach (sketch_mem[i]) sketch_mem[i] = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    foreach (table_rows[i]) send_row(table_rows[i]);
    in_ch.valid <= 1'b0;
    @(posedge clk);

    // long receiver hold-off while requests keep coming, to fill the queue
    fork
      begin
        hold_off = 1'b1;
        repeat (3000) @(posedge clk);
        hold_off = 1'b0;
      end
      random_phase(8);
    join

    // settings sweep; zero and oversized values hit the saturation cases
    write_cfg(CFG_ROWS, 11'd1);  write_cfg(CFG_COLS, 11'd1);
    write_cfg(CFG_HASHES, 11'd4);
    random_phase(150);
    write_cfg(CFG_COLS, 11'd0);  write_cfg(CFG_HASHES, 11'd7);
    random_phase(100);

    send_idle_pct = 86; recv_idle_pct = 31;
    write_cfg(CFG_ROWS, 11'd7);  write_cfg(CFG_COLS, 11'd2047);
    write_cfg(CFG_HASHES, 11'd2);
    random_phase(250);
    // modulus change without moving counters
    write_cfg(CFG_COLS, 11'd13);
    random_phase(200);
    write_cfg(CFG_ROWS, 11'd0);
    random_phase(60);
    write_cfg(CFG_ROWS, 11'd3);  write_cfg(CFG_HASHES, 11'd0);
    random_phase(60);

    send_idle_pct = 0; recv_idle_pct = 0;
    write_cfg(CFG_ROWS, 11'd2);  write_cfg(CFG_COLS, 11'd1024);
    write_cfg(CFG_HASHES, 11'd1);
    random_phase(400);
    write_cfg(CFG_ROWS, 11'd4);  write_cfg(CFG_COLS, 11'd1023);
    write_cfg(CFG_HASHES, 11'd3);
    random_phase(350);

    // drain, then allow any clear still running to finish
    while (expected_q.size() != 0) @(posedge clk);
    done_flag = 1'b1;
    repeat (4200) @(posedge clk);
    if (fail_count == 0 && expected_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
